// ===== rtl/srconv_pkg.sv =====
// Shared types and constants for the separable row convolver.
// Holds the item structs on both channels, the queue entry and the register codes.
// Depends on nothing else.
package srconv_pkg;

	localparam int PIX_W        = 8;
	localparam int COORD_W      = 12;
	localparam int COEF_W       = 16;
	localparam int NUM_TAPS     = 5;
	localparam int CFG_IDX_W    = 3;

	localparam int MAX_LINE_DEFAULT    = 4096;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Datapath widths of the weighted sum and the rounding divide.
	localparam int PROD_W = COEF_W + PIX_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam int WSUM_W = COEF_W + 3;
	localparam int NUM_W  = ACC_W + 1;
	localparam int DEN_W  = WSUM_W + 1;

	// Tap order matches the register order: left2, left1, centre, right1, right2.
	localparam int TAP_L2 = 0;
	localparam int TAP_L1 = 1;
	localparam int TAP_C  = 2;
	localparam int TAP_R1 = 3;
	localparam int TAP_R2 = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_LEFT2  = 3'd0,
		REG_COEF_LEFT1  = 3'd1,
		REG_COEF_CENTRE = 3'd2,
		REG_COEF_RIGHT1 = 3'd3,
		REG_COEF_RIGHT2 = 3'd4
	} cfg_reg_t;

	localparam logic [COEF_W-1:0] COEF_RESET_SIDE   = 16'd0;
	localparam logic [COEF_W-1:0] COEF_RESET_CENTRE = 16'hFFFF;

	typedef logic [NUM_TAPS-1:0][COEF_W-1:0] coef_set_t;
	typedef logic [NUM_TAPS-1:0][PIX_W-1:0]  window_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             row_end;
		logic             image_start;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]   out_pixel;
		logic [COORD_W-1:0] out_row;
		logic [COORD_W-1:0] out_col;
		logic               run_last;
	} res_t;

	// One queued input item: the window after the shift (element 0 newest), the column of the
	// newest pixel, its row, whether it closes the row, and col_ge[i] = (column >= i + 1).
	typedef struct packed {
		window_t            win;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [3:0]         col_ge;
		logic               row_done;
	} job_t;

endpackage

// ===== rtl/srconv_front.sv =====
// Front end of the separable row convolver: pixel window, column and row counters.
// Classifies each pixel and queues those that give results. Uses srconv_pkg.
module srconv_front #(
	parameter int MAX_LINE = srconv_pkg::MAX_LINE_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  srconv_pkg::pix_in_t pix,
	input  logic                queue_full,
	output logic                push,
	output srconv_pkg::job_t    entry
);

	localparam int CW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

	srconv_pkg::window_t                   win_q;
	logic [CW-1:0]                         col_q;
	logic [srconv_pkg::COORD_W-1:0]        row_q;

	srconv_pkg::window_t                   win_new;
	logic [CW-1:0]                         col_eff;
	logic [srconv_pkg::COORD_W-1:0]        row_eff;
	logic                                  ends;
	logic                                  has_result;
	logic                                  accept;

	always_comb begin
		col_eff    = pix.image_start ? '0 : col_q;
		row_eff    = pix.image_start ? '0 : row_q;
		win_new    = {win_q[srconv_pkg::NUM_TAPS-2:0], pix.pixel};
		// An overlong row is closed as if row_end were set.
		ends       = pix.row_end || (col_eff == CW'(MAX_LINE - 1));
		has_result = ends || (32'(col_eff) >= 32'd2);
		accept     = pix_valid && pix_ready;

		entry.win      = win_new;
		entry.col      = srconv_pkg::COORD_W'(col_eff);
		entry.row      = row_eff;
		entry.row_done = ends;
		for (int i = 0; i < 4; i++) begin
			entry.col_ge[i] = 32'(col_eff) >= 32'(i + 1);
		end
	end

	assign pix_ready = !queue_full;
	assign push      = accept && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			win_q <= win_new;
			if (ends) begin
				col_q <= '0;
				row_q <= row_eff + 1'b1;
			end else begin
				col_q <= col_eff + 1'b1;
				row_q <= row_eff;
			end
		end
	end

endmodule

// ===== rtl/srconv_queue.sv =====
// Small flip-flop queue between the front and back ends of the row convolver.
// Holds srconv_pkg::job_t entries; the head is visible without a pop.
module srconv_queue #(
	parameter int DEPTH = srconv_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  srconv_pkg::job_t push_data,
	input  logic             pop,
	output srconv_pkg::job_t head,
	output logic             full,
	output logic             empty
);

	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	srconv_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CNW-1:0]    count_q;

	assign full  = (count_q == CNW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/srconv_back.sv =====
// Back end of the row convolver: expands a queued item into its results, forms the
// weighted sum and divides it by the weight sum one quotient bit per cycle. Uses srconv_pkg.
module srconv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  srconv_pkg::job_t      head,
	input  logic                  empty,
	output logic                  pop,
	input  srconv_pkg::coef_set_t coef,
	output logic                  res_valid,
	input  logic                  res_ready,
	output srconv_pkg::res_t      res
);

	localparam int QBW = $clog2(srconv_pkg::PIX_W);

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_SUM, ST_DIV, ST_OUT} state_t;

	// Which result of the item: centre two left of, one left of, or at the newest pixel.
	typedef enum logic [1:0] {JOB_BACK2, JOB_BACK1, JOB_CENTRE} job_sel_t;

	state_t                                state_q;
	job_sel_t                              job_q;
	srconv_pkg::job_t                      entry_q;
	logic [srconv_pkg::PROD_W-1:0]         prod_q [srconv_pkg::NUM_TAPS];
	logic [srconv_pkg::NUM_W-1:0]          rem_q;
	logic [srconv_pkg::NUM_W-1:0]          sh_q;
	logic [srconv_pkg::PIX_W-1:0]          quo_q;
	logic [QBW-1:0]                        bit_q;
	logic                                  zero_q;
	logic                                  res_valid_q;
	srconv_pkg::res_t                      res_q;

	srconv_pkg::window_t                   tap;
	logic                                  l2ok;
	logic                                  l1ok;
	logic [srconv_pkg::PROD_W-1:0]         prod_d [srconv_pkg::NUM_TAPS];
	logic [srconv_pkg::ACC_W-1:0]          acc;
	logic [srconv_pkg::WSUM_W-1:0]         wsum;
	logic [srconv_pkg::NUM_W-1:0]          num;
	logic [srconv_pkg::DEN_W-1:0]          den;
	logic                                  div_ge;
	logic [srconv_pkg::COORD_W-1:0]        offset;
	logic                                  job_last;
	logic                                  item_done;
	logic                                  out_load;
	job_sel_t                              job_start;

	// Tap selection; a neighbor outside the row takes the centre pixel.
	always_comb begin
		tap    = '0;
		l2ok   = 1'b0;
		l1ok   = 1'b0;
		offset = '0;
		case (job_q)
			JOB_BACK2: begin
				tap[srconv_pkg::TAP_L2] = entry_q.win[4];
				tap[srconv_pkg::TAP_L1] = entry_q.win[3];
				tap[srconv_pkg::TAP_C]  = entry_q.win[2];
				tap[srconv_pkg::TAP_R1] = entry_q.win[1];
				tap[srconv_pkg::TAP_R2] = entry_q.win[0];
				l2ok   = entry_q.col_ge[3];
				l1ok   = entry_q.col_ge[2];
				offset = srconv_pkg::COORD_W'(2);
			end
			JOB_BACK1: begin
				tap[srconv_pkg::TAP_L2] = entry_q.win[3];
				tap[srconv_pkg::TAP_L1] = entry_q.win[2];
				tap[srconv_pkg::TAP_C]  = entry_q.win[1];
				tap[srconv_pkg::TAP_R1] = entry_q.win[0];
				tap[srconv_pkg::TAP_R2] = entry_q.win[1];
				l2ok   = entry_q.col_ge[2];
				l1ok   = entry_q.col_ge[1];
				offset = srconv_pkg::COORD_W'(1);
			end
			JOB_CENTRE: begin
				tap[srconv_pkg::TAP_L2] = entry_q.win[2];
				tap[srconv_pkg::TAP_L1] = entry_q.win[1];
				tap[srconv_pkg::TAP_C]  = entry_q.win[0];
				tap[srconv_pkg::TAP_R1] = entry_q.win[0];
				tap[srconv_pkg::TAP_R2] = entry_q.win[0];
				l2ok   = entry_q.col_ge[1];
				l1ok   = entry_q.col_ge[0];
				offset = '0;
			end
			default: begin
				tap    = '0;
				l2ok   = 1'b0;
				l1ok   = 1'b0;
				offset = '0;
			end
		endcase
		if (!l2ok) begin
			tap[srconv_pkg::TAP_L2] = tap[srconv_pkg::TAP_C];
		end
		if (!l1ok) begin
			tap[srconv_pkg::TAP_L1] = tap[srconv_pkg::TAP_C];
		end
	end

	always_comb begin
		for (int i = 0; i < srconv_pkg::NUM_TAPS; i++) begin
			prod_d[i] = srconv_pkg::PROD_W'(coef[i]) * srconv_pkg::PROD_W'(tap[i]);
		end
		acc  = '0;
		wsum = '0;
		for (int i = 0; i < srconv_pkg::NUM_TAPS; i++) begin
			acc  = acc + srconv_pkg::ACC_W'(prod_q[i]);
			wsum = wsum + srconv_pkg::WSUM_W'(coef[i]);
		end
		// Round half up: floor((2*acc + wsum) / (2*wsum)).
		num    = srconv_pkg::NUM_W'({acc, 1'b0}) + srconv_pkg::NUM_W'(wsum);
		den    = {wsum, 1'b0};
		div_ge = (rem_q >= sh_q);

		job_last  = (job_q == JOB_CENTRE);
		item_done = job_last || ((job_q == JOB_BACK2) && !entry_q.row_done);
		out_load  = (state_q == ST_OUT) && (!res_valid_q || res_ready);
		if (head.col_ge[1]) begin
			job_start = JOB_BACK2;
		end else if (head.col_ge[0]) begin
			job_start = JOB_BACK1;
		end else begin
			job_start = JOB_CENTRE;
		end
	end

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JOB_BACK2;
			entry_q     <= '0;
			for (int i = 0; i < srconv_pkg::NUM_TAPS; i++) begin
				prod_q[i] <= '0;
			end
			rem_q       <= '0;
			sh_q        <= '0;
			quo_q       <= '0;
			zero_q      <= 1'b0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			bit_q       <= '0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						entry_q <= head;
						job_q   <= job_start;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					for (int i = 0; i < srconv_pkg::NUM_TAPS; i++) begin
						prod_q[i] <= prod_d[i];
					end
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					rem_q   <= num;
					sh_q    <= srconv_pkg::NUM_W'(den) << (srconv_pkg::PIX_W - 1);
					zero_q  <= (wsum == '0);
					quo_q   <= '0;
					bit_q   <= QBW'(srconv_pkg::PIX_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// The quotient never exceeds 255, so eight restoring steps cover it
					// and no clamp to 255 is needed.
					if (div_ge) begin
						rem_q <= rem_q - sh_q;
					end
					sh_q  <= sh_q >> 1;
					quo_q <= {quo_q[srconv_pkg::PIX_W-2:0], div_ge};
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						res_q.out_pixel   <= zero_q ? '0 : quo_q;
						res_q.out_row     <= entry_q.col - offset;
						res_q.out_col     <= entry_q.row;
						res_q.run_last    <= job_last;
						if (item_done) begin
							state_q <= ST_IDLE;
						end else begin
							job_q   <= (job_q == JOB_BACK2) ? JOB_BACK1 : JOB_CENTRE;
							state_q <= ST_MUL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/separable_row_convolver.sv =====
// A pixel is taken whenever the four-entry queue between the front end and the arithmetic
// back end has room. A pixel that gives no result costs nothing further; each result passes
// through a multiply, a sum, eight divide steps for the round-half-up quotient and an output
// load, which waits while the receiver stalls, and a queued pixel is first popped in the idle
// state. A row end gives up to three results. The single bit-serial divider is shared, so the
// back end finishes one result before it starts the next. Results come out in input order
// with transposed coordinates; a zero weight sum gives 0. The user must write coefficients
// only when the block is idle; the block itself does not enforce this.
//
// Top level of the separable row convolver: coefficient registers and the front, queue and
// back ends. Depends on srconv_pkg, srconv_front, srconv_queue and srconv_back.
module separable_row_convolver #(
	parameter int MAX_LINE    = srconv_pkg::MAX_LINE_DEFAULT,
	parameter int QUEUE_DEPTH = srconv_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_ready,
	input  srconv_pkg::pix_in_t                 pix,
	output logic                                res_valid,
	input  logic                                res_ready,
	output srconv_pkg::res_t                    res,
	input  logic                                cfg_we,
	input  logic [srconv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srconv_pkg::COEF_W-1:0]       cfg_wdata
);

	srconv_pkg::coef_set_t coef_q;
	srconv_pkg::job_t      push_data;
	srconv_pkg::job_t      head;
	logic                  push;
	logic                  pop;
	logic                  full;
	logic                  empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[srconv_pkg::TAP_L2] <= srconv_pkg::COEF_RESET_SIDE;
			coef_q[srconv_pkg::TAP_L1] <= srconv_pkg::COEF_RESET_SIDE;
			coef_q[srconv_pkg::TAP_C]  <= srconv_pkg::COEF_RESET_CENTRE;
			coef_q[srconv_pkg::TAP_R1] <= srconv_pkg::COEF_RESET_SIDE;
			coef_q[srconv_pkg::TAP_R2] <= srconv_pkg::COEF_RESET_SIDE;
		end else if (cfg_we) begin
			case (cfg_index)
				srconv_pkg::REG_COEF_LEFT2:  coef_q[srconv_pkg::TAP_L2] <= cfg_wdata;
				srconv_pkg::REG_COEF_LEFT1:  coef_q[srconv_pkg::TAP_L1] <= cfg_wdata;
				srconv_pkg::REG_COEF_CENTRE: coef_q[srconv_pkg::TAP_C]  <= cfg_wdata;
				srconv_pkg::REG_COEF_RIGHT1: coef_q[srconv_pkg::TAP_R1] <= cfg_wdata;
				srconv_pkg::REG_COEF_RIGHT2: coef_q[srconv_pkg::TAP_R2] <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	srconv_front #(
		.MAX_LINE(MAX_LINE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.queue_full(full),
		.push      (push),
		.entry     (push_data)
	);

	srconv_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	srconv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.coef     (coef_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

// ===== tb/tb_separable_row_convolver.sv =====
// Self-checking testbench for separable_row_convolver: drives pixel rows and kernels.
// A small tracker class predicts every filtered result; depends on srconv_pkg and the RTL.
module tb_separable_row_convolver;
	timeunit 1ns;
	timeprecision 1ps;

	import srconv_pkg::*;

	localparam int IDLE_LIMIT    = 1000;
	localparam int SETTLE_CYCLES = 48;

	// Tracks the row filter state and holds the results still due from the block.
	class row_blur_tracker;
		coef_set_t        weights;
		logic [PIX_W-1:0] win [NUM_TAPS];
		int               col_cnt;
		logic [COORD_W-1:0] row_cnt;
		res_t             due_results[$];
		int               mismatches;

		function new();
			weights = '0;
			weights[TAP_C] = COEF_RESET_CENTRE;
			for (int i = 0; i < NUM_TAPS; i++) win[i] = '0;
			col_cnt = 0;
			row_cnt = '0;
			mismatches = 0;
		endfunction

		function void set_kernel(coef_set_t k);
			weights = k;
		endfunction

		// Neighbours outside the row take the centre value.
		function void queue_result(logic [7:0] l2, logic [7:0] l1, logic [7:0] c,
				logic [7:0] r1, logic [7:0] r2, bit r1ok, bit r2ok, int k, bit last);
			res_t r;
			logic [7:0] a, b, d, e;
			longint unsigned acc, wsum, q;
			a = (k >= 2) ? l2 : c;
			b = (k >= 1) ? l1 : c;
			d = r1ok ? r1 : c;
			e = r2ok ? r2 : c;
			wsum = 64'(weights[TAP_L2]) + weights[TAP_L1] + weights[TAP_C]
				+ weights[TAP_R1] + weights[TAP_R2];
			if (wsum == 0) begin
				q = 0;
			end else begin
				acc = 64'(weights[TAP_L2]) * a + 64'(weights[TAP_L1]) * b
					+ 64'(weights[TAP_C]) * c + 64'(weights[TAP_R1]) * d
					+ 64'(weights[TAP_R2]) * e;
				q = (2 * acc + wsum) / (2 * wsum);
				if (q > 255) q = 255;
			end
			r.out_pixel = q[7:0];
			r.out_row = k[COORD_W-1:0];
			r.out_col = row_cnt;
			r.run_last = last;
			due_results.push_back(r);
		endfunction

		function void take_pixel(pix_in_t p);
			int col;
			bit closes;
			if (p.image_start) begin
				col_cnt = 0;
				row_cnt = '0;
			end
			col = col_cnt;
			for (int i = NUM_TAPS - 1; i > 0; i--) win[i] = win[i-1];
			win[0] = p.pixel;
			closes = p.row_end || (col + 1 >= MAX_LINE_DEFAULT);
			if (col >= 2)
				queue_result(win[4], win[3], win[2], win[1], win[0], 1, 1, col - 2, 0);
			if (closes) begin
				if (col >= 1)
					queue_result(win[3], win[2], win[1], win[0], 8'd0, 1, 0, col - 1, 0);
				queue_result(win[2], win[1], win[0], 8'd0, 8'd0, 0, 0, col, 1);
				col_cnt = 0;
				row_cnt = row_cnt + 1'b1;
			end else begin
				col_cnt = col + 1;
			end
		endfunction

		function void match_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, ", $time,
					"actual pixel %0d row %0d col %0d last %0d",
					got.out_pixel, got.out_row, got.out_col, got.run_last);
			end else begin
				want = due_results.pop_front();
				if (got.out_pixel !== want.out_pixel || got.out_row !== want.out_row ||
						got.out_col !== want.out_col || got.run_last !== want.run_last) begin
					mismatches++;
					$display("%0t: expected pixel %0d row %0d col %0d last %0d, ", $time,
						want.out_pixel, want.out_row, want.out_col, want.run_last,
						"actual pixel %0d row %0d col %0d last %0d",
						got.out_pixel, got.out_row, got.out_col, got.run_last);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 pix_valid = 1'b0;
	logic                 pix_ready;
	pix_in_t              pix = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_t                 res;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_COEF_LEFT2;
	logic [COEF_W-1:0]    cfg_wdata = '0;

	bit                   calm = 1'b0;
	int unsigned          hold_left = 0;
	int unsigned          quiet_cycles = 0;
	row_blur_tracker      tracker = new();

	separable_row_convolver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver stalls come in bursts of random length unless calm is set.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			hold_left <= $urandom_range(0, 6);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			tracker.match_result(res);
		if ((pix_valid && pix_ready) || (res_valid && res_ready) || cfg_we || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic pix_in_t pixel_item(logic [PIX_W-1:0] v, logic re, logic st);
		pix_in_t p;
		p.pixel = v;
		p.row_end = re;
		p.image_start = st;
		return p;
	endfunction

	function automatic coef_set_t random_kernel();
		coef_set_t k;
		for (int i = 0; i < NUM_TAPS; i++) begin
			case ($urandom_range(0, 4))
				0: k[i] = '0;
				1: k[i] = 16'hFFFF;
				2: k[i] = COEF_W'($urandom_range(1, 3));
				default: k[i] = COEF_W'($urandom_range(0, 65535));
			endcase
		end
		return k;
	endfunction

	function automatic coef_set_t kernel_for_phase(int n);
		coef_set_t k;
		k = '0;
		case (n)
			0: k = {NUM_TAPS{16'hFFFF}};
			1: k = '0;
			2: k[TAP_L2] = 16'hFFFF;
			3: k[TAP_R2] = 16'd1;
			default: k = random_kernel();
		endcase
		return k;
	endfunction

	task automatic send_pixel(input pix_in_t p);
		if (!calm && $urandom_range(0, 3) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pix <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		tracker.take_pixel(p);
	endtask

	// Called right after the last transfer, so valid drops once the burst is sent.
	task automatic finish_burst();
		pix_valid <= 1'b0;
	endtask

	task automatic settle();
		while (tracker.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_kernel(input coef_set_t k);
		for (int i = 0; i < NUM_TAPS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_wdata <= k[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		tracker.set_kernel(k);
	endtask

	task automatic directed_rows();
		send_pixel(pixel_item(8'd0, 1'b1, 1'b1));
		send_pixel(pixel_item(8'd255, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd0, 1'b1, 1'b0));
		send_pixel(pixel_item(8'd255, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd0, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd255, 1'b1, 1'b0));
		send_pixel(pixel_item(8'd10, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd255, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd0, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd255, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd128, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd1, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd254, 1'b1, 1'b0));
		// A new image in the middle of a row drops what that row still owed.
		send_pixel(pixel_item(8'd200, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd100, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd50, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd7, 1'b0, 1'b1));
		send_pixel(pixel_item(8'd9, 1'b0, 1'b0));
		send_pixel(pixel_item(8'd255, 1'b1, 1'b0));
	endtask

	task automatic random_stream(input int count);
		int left;
		bit fresh;
		pix_in_t p;
		left = 0;
		repeat (count) begin
			fresh = (left == 0);
			if (fresh)
				left = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
			case ($urandom_range(0, 9))
				0: p.pixel = 8'hFF;
				1: p.pixel = 8'h00;
				default: p.pixel = PIX_W'($urandom_range(0, 255));
			endcase
			left = left - 1;
			p.row_end = (left == 0);
			p.image_start = fresh && ($urandom_range(0, 11) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// Broken framing: the row and image marks are set at random.
				p.row_end = 1'($urandom_range(0, 1));
				p.image_start = 1'($urandom_range(0, 1));
				if (p.row_end) left = 0;
			end
			send_pixel(p);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_rows();
		finish_burst();
		settle();

		for (int n = 0; n < 7; n++) begin
			if (n == 6) calm = 1'b1;
			load_kernel(kernel_for_phase(n));
			random_stream(22);
			finish_burst();
			settle();
		end

		if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/srconv_pkg.sv
rtl/srconv_front.sv
rtl/srconv_queue.sv
rtl/srconv_back.sv
rtl/separable_row_convolver.sv
tb/tb_separable_row_convolver.sv
